/* design/jsu_pkg.sv */
package jsu_pkg;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  localparam logic [1:0] KindData = 2'd0;
  localparam logic [1:0] KindDone = 2'd1;
  localparam logic [1:0] KindErr  = 2'd2;

  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChU      = 8'h75;
  localparam logic [7:0] ChEnd    = 8'h00;

  localparam logic [15:0] Utf8TwoMin   = 16'h0080;
  localparam logic [15:0] Utf8ThreeMin = 16'h0800;
  localparam logic [7:0]  Utf8Lead2    = 8'hC0;
  localparam logic [7:0]  Utf8Lead3    = 8'hE0;
  localparam logic [7:0]  Utf8Cont     = 8'h80;
  localparam logic [5:0]  Utf8Mask     = 6'h3F;

  typedef enum logic [3:0] {
    ModeIdle = 4'b0001,
    ModeStr  = 4'b0010,
    ModeEsc  = 4'b0100,
    ModeHex  = 4'b1000
  } mode_e;

  // One classified input: one to three results, all of one kind.
  typedef struct packed {
    logic [1:0]      cnt;
    logic [1:0]      kind;
    logic [2:0][7:0] bytes;
  } entry_t;

  function automatic logic [3:0] hex_value(input logic [7:0] b);
    logic [3:0] v;
    v = 4'd0;
    case (b) inside
      [8'h30:8'h39]: v = 4'(b - 8'h30);
      [8'h61:8'h66]: v = 4'(b - 8'h61 + 8'd10);
      [8'h41:8'h46]: v = 4'(b - 8'h41 + 8'd10);
      default:       v = 4'd0;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] escape_map(input logic [7:0] e);
    logic [7:0] r;
    case (e)
      8'h6E:   r = 8'h0A;
      8'h74:   r = 8'h09;
      8'h72:   r = 8'h0D;
      8'h62:   r = 8'h08;
      8'h66:   r = 8'h0C;
      default: r = e;
    endcase
    return r;
  endfunction

endpackage

/* design/jsu_front.sv */
module jsu_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [7:0]      in_byte_i,
  output logic            gen_o,
  output jsu_pkg::entry_t entry_o
);

  jsu_pkg::mode_e mode_q, mode_d;
  logic [1:0]     hex_count_q, hex_count_d;
  logic [15:0]    code_point_q, code_point_d;
  logic [15:0]    cp_new;

  assign cp_new = {code_point_q[11:0], jsu_pkg::hex_value(in_byte_i)};

  always_comb begin
    mode_d       = mode_q;
    hex_count_d  = hex_count_q;
    code_point_d = code_point_q;
    gen_o        = 1'b0;
    entry_o      = '0;
    case (mode_q)
      jsu_pkg::ModeIdle: begin
        if (in_byte_i != jsu_pkg::ChQuote) begin
          gen_o        = 1'b1;
          entry_o.cnt  = 2'd1;
          entry_o.kind = jsu_pkg::KindErr;
        end else begin
          mode_d = jsu_pkg::ModeStr;
        end
      end
      jsu_pkg::ModeStr: begin
        if (in_byte_i == jsu_pkg::ChEnd) begin
          gen_o        = 1'b1;
          entry_o.cnt  = 2'd1;
          entry_o.kind = jsu_pkg::KindErr;
          mode_d       = jsu_pkg::ModeIdle;
        end else if (in_byte_i == jsu_pkg::ChQuote) begin
          gen_o        = 1'b1;
          entry_o.cnt  = 2'd1;
          entry_o.kind = jsu_pkg::KindDone;
          mode_d       = jsu_pkg::ModeIdle;
        end else if (in_byte_i == jsu_pkg::ChBslash) begin
          mode_d = jsu_pkg::ModeEsc;
        end else begin
          gen_o            = 1'b1;
          entry_o.cnt      = 2'd1;
          entry_o.kind     = jsu_pkg::KindData;
          entry_o.bytes[0] = in_byte_i;
        end
      end
      jsu_pkg::ModeEsc: begin
        if (in_byte_i == jsu_pkg::ChEnd) begin
          gen_o        = 1'b1;
          entry_o.cnt  = 2'd1;
          entry_o.kind = jsu_pkg::KindErr;
          mode_d       = jsu_pkg::ModeIdle;
        end else if (in_byte_i == jsu_pkg::ChU) begin
          mode_d       = jsu_pkg::ModeHex;
          hex_count_d  = 2'd0;
          code_point_d = 16'd0;
        end else begin
          gen_o            = 1'b1;
          entry_o.cnt      = 2'd1;
          entry_o.kind     = jsu_pkg::KindData;
          entry_o.bytes[0] = jsu_pkg::escape_map(in_byte_i);
          mode_d           = jsu_pkg::ModeStr;
        end
      end
      jsu_pkg::ModeHex: begin
        if (in_byte_i == jsu_pkg::ChEnd) begin
          gen_o        = 1'b1;
          entry_o.cnt  = 2'd1;
          entry_o.kind = jsu_pkg::KindErr;
          mode_d       = jsu_pkg::ModeIdle;
          hex_count_d  = 2'd0;
          code_point_d = 16'd0;
        end else if (hex_count_q == 2'd3) begin
          gen_o        = 1'b1;
          entry_o.kind = jsu_pkg::KindData;
          if (cp_new < jsu_pkg::Utf8TwoMin) begin
            entry_o.cnt      = 2'd1;
            entry_o.bytes[0] = cp_new[7:0];
          end else if (cp_new < jsu_pkg::Utf8ThreeMin) begin
            entry_o.cnt      = 2'd2;
            entry_o.bytes[0] = jsu_pkg::Utf8Lead2 | {3'd0, cp_new[10:6]};
            entry_o.bytes[1] = jsu_pkg::Utf8Cont | {2'd0, cp_new[5:0] & jsu_pkg::Utf8Mask};
          end else begin
            entry_o.cnt      = 2'd3;
            entry_o.bytes[0] = jsu_pkg::Utf8Lead3 | {4'd0, cp_new[15:12]};
            entry_o.bytes[1] = jsu_pkg::Utf8Cont | {2'd0, cp_new[11:6] & jsu_pkg::Utf8Mask};
            entry_o.bytes[2] = jsu_pkg::Utf8Cont | {2'd0, cp_new[5:0] & jsu_pkg::Utf8Mask};
          end
          hex_count_d  = 2'd0;
          code_point_d = 16'd0;
          mode_d       = jsu_pkg::ModeStr;
        end else begin
          hex_count_d  = hex_count_q + 2'd1;
          code_point_d = cp_new;
        end
      end
      default: begin
        mode_d       = jsu_pkg::ModeIdle;
        hex_count_d  = 2'd0;
        code_point_d = 16'd0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= jsu_pkg::ModeIdle;
      hex_count_q  <= 2'd0;
      code_point_q <= 16'd0;
    end else if (accept_i) begin
      mode_q       <= mode_d;
      hex_count_q  <= hex_count_d;
      code_point_q <= code_point_d;
    end
  end

`ifndef SYNTHESIS
  a_hex_count_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q != jsu_pkg::ModeHex) |-> (hex_count_q == 2'd0))
    else $error("hex count left non-zero outside a unicode escape");

  a_multi_is_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (gen_o && entry_o.cnt != 2'd1) |-> (entry_o.kind == jsu_pkg::KindData))
    else $error("multi-byte result that is not data");
`endif

endmodule

/* design/jsu_fifo.sv */
module jsu_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_i,
  input  jsu_pkg::entry_t wr_data_i,
  input  logic            rd_i,
  output jsu_pkg::entry_t rd_data_o,
  output logic            full_o,
  output logic            nonempty_o
);

  jsu_pkg::entry_t                mem_q [jsu_pkg::FifoDepth];
  logic [jsu_pkg::FifoPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [jsu_pkg::FifoCntW-1:0]   count_q;

  assign full_o     = count_q == jsu_pkg::FifoCntW'(jsu_pkg::FifoDepth);
  assign nonempty_o = count_q != '0;
  assign rd_data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_i) begin
        wr_ptr_q <= wr_ptr_q + jsu_pkg::FifoPtrW'(1);
      end
      if (rd_i) begin
        rd_ptr_q <= rd_ptr_q + jsu_pkg::FifoPtrW'(1);
      end
      if (wr_i && !rd_i) begin
        count_q <= count_q + jsu_pkg::FifoCntW'(1);
      end else if (!wr_i && rd_i) begin
        count_q <= count_q - jsu_pkg::FifoCntW'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_i |-> !full_o)
    else $error("write into a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_i |-> nonempty_o)
    else $error("read from an empty queue");
`endif

endmodule

/* design/jsu_back.sv */
module jsu_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            head_valid_i,
  input  jsu_pkg::entry_t head_i,
  input  logic            pop,
  output logic            head_rd_o,
  output logic            empty,
  output logic [7:0]      out_byte_o,
  output logic [1:0]      kind_o,
  output logic            last_o
);

  logic [1:0] idx_q;
  logic       xfer;

  assign empty      = !head_valid_i;
  assign xfer       = pop && head_valid_i;
  assign last_o     = idx_q == (head_i.cnt - 2'd1);
  assign out_byte_o = (idx_q == 2'd3) ? 8'd0 : head_i.bytes[idx_q];
  assign kind_o     = head_i.kind;
  assign head_rd_o  = xfer && last_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
    end else if (xfer) begin
      idx_q <= last_o ? 2'd0 : idx_q + 2'd1;
    end
  end

`ifndef SYNTHESIS
  a_idx_in_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i |-> (idx_q < head_i.cnt))
    else $error("result index beyond its entry");

  a_idx_rewinds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_rd_o |=> (idx_q == 2'd0))
    else $error("result index not rewound after the last transfer");
`endif

endmodule

/* design/json_string_unescape_unit.sv */
// Streaming unescaper for one JSON string token: bytes enter at push/full, one per
// cycle while full is low, starting at the opening quote, and decoded bytes, a done
// marker or an error marker leave at empty/pop, one per cycle while empty is low;
// last flags the final result of an input. The front classifies each byte in the
// cycle it is accepted and writes up to three results as one entry into a four-deep
// queue; the back walks the head entry one result per pop. Results are registered in
// the queue before they reach the ports. Sustained intake is one byte a cycle as long
// as results are popped at the rate they are made; full rises when four entries wait.
module json_string_unescape_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic [1:0] kind_o,
  output logic       last_o
);

  logic            accept;
  logic            gen;
  jsu_pkg::entry_t entry;
  jsu_pkg::entry_t head;
  logic            head_valid;
  logic            head_rd;

  assign accept = push && !full;

  jsu_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_byte_i (in_byte_i),
    .gen_o     (gen),
    .entry_o   (entry)
  );

  jsu_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (accept && gen),
    .wr_data_i  (entry),
    .rd_i       (head_rd),
    .rd_data_o  (head),
    .full_o     (full),
    .nonempty_o (head_valid)
  );

  jsu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop          (pop),
    .head_rd_o    (head_rd),
    .empty        (empty),
    .out_byte_o   (out_byte_o),
    .kind_o       (kind_o),
    .last_o       (last_o)
  );

endmodule
